// ===== hw/rtl/tcwm_pkg.sv =====
package tcwm_pkg;

    localparam int ANGLE_W = 16;
    localparam int ID_W    = 17;
    localparam int SLOT_W  = 12;
    localparam int COUNT_W = 13;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic CFG_TOLERANCE = 1'b0;
    localparam logic CFG_COUNT     = 1'b1;

    localparam logic [ANGLE_W-1:0] TOL_RESET = 16'd26;

    typedef struct packed {
        logic               mode;
        logic [SLOT_W-1:0]  entry_index;
        logic [ANGLE_W-1:0] angle_small;
        logic [ANGLE_W-1:0] angle_mid;
        logic [ANGLE_W-1:0] angle_large;
        logic [ID_W-1:0]    star_id_a;
        logic [ID_W-1:0]    star_id_b;
        logic [ID_W-1:0]    star_id_c;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] match_index;
        logic [ID_W-1:0]   match_star_a;
        logic [ID_W-1:0]   match_star_b;
        logic [ID_W-1:0]   match_star_c;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic [ANGLE_W-1:0] small_a;
        logic [ANGLE_W-1:0] mid_a;
        logic [ANGLE_W-1:0] large_a;
        logic [ID_W-1:0]    id_a;
        logic [ID_W-1:0]    id_b;
        logic [ID_W-1:0]    id_c;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BS_RD,
        S_BS_EV,
        S_DN_RD,
        S_DN_EV,
        S_UP_RD,
        S_UP_EV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        logic bs_rd;
        logic bs_ev;
        logic scan_init;
        logic rd_dn;
        logic rd_up;
        logic visit_dn;
        logic visit_up;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic in_query;
        logic count_zero;
        logic bs_done;
        logic ptr_zero;
        logic ptr_end;
        logic in_tol;
        logic emit_wait;
        logic out_free;
    } t_status;

    function automatic logic [ANGLE_W-1:0] abs_diff(input logic [ANGLE_W-1:0] a,
                                                    input logic [ANGLE_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== hw/rtl/tcwm_ctrl.sv =====
module tcwm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tcwm_pkg::t_status i_status,
    output logic              o_in_stall,
    output tcwm_pkg::t_cmd    o_cmd
);

    tcwm_pkg::t_state r_state;
    tcwm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcwm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tcwm_pkg::S_IDLE: begin
                if (i_in_valid && i_status.in_query) begin
                    n_state = i_status.count_zero ? tcwm_pkg::S_FIN : tcwm_pkg::S_BS_RD;
                end
            end
            tcwm_pkg::S_BS_RD: n_state = tcwm_pkg::S_BS_EV;
            tcwm_pkg::S_BS_EV: begin
                n_state = i_status.bs_done ? tcwm_pkg::S_DN_RD : tcwm_pkg::S_BS_RD;
            end
            tcwm_pkg::S_DN_RD: begin
                n_state = i_status.ptr_zero ? tcwm_pkg::S_UP_RD : tcwm_pkg::S_DN_EV;
            end
            tcwm_pkg::S_DN_EV: begin
                if (!i_status.in_tol) begin
                    n_state = tcwm_pkg::S_UP_RD;
                end else if (!i_status.emit_wait) begin
                    n_state = tcwm_pkg::S_DN_RD;
                end
            end
            tcwm_pkg::S_UP_RD: begin
                n_state = i_status.ptr_end ? tcwm_pkg::S_FIN : tcwm_pkg::S_UP_EV;
            end
            tcwm_pkg::S_UP_EV: begin
                if (!i_status.in_tol) begin
                    n_state = tcwm_pkg::S_FIN;
                end else if (!i_status.emit_wait) begin
                    n_state = tcwm_pkg::S_UP_RD;
                end
            end
            tcwm_pkg::S_FIN: begin
                if (i_status.out_free) begin
                    n_state = tcwm_pkg::S_IDLE;
                end
            end
            default: n_state = tcwm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            tcwm_pkg::S_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.load  = i_in_valid && !i_status.in_query;
                o_cmd.start = i_in_valid && i_status.in_query;
            end
            tcwm_pkg::S_BS_RD: o_cmd.bs_rd = 1'b1;
            tcwm_pkg::S_BS_EV: o_cmd.bs_ev = 1'b1;
            tcwm_pkg::S_DN_RD: begin
                o_cmd.scan_init = i_status.ptr_zero;
                o_cmd.rd_dn     = !i_status.ptr_zero;
            end
            tcwm_pkg::S_DN_EV: begin
                o_cmd.scan_init = !i_status.in_tol;
                o_cmd.visit_dn  = i_status.in_tol && !i_status.emit_wait;
            end
            tcwm_pkg::S_UP_RD: o_cmd.rd_up = !i_status.ptr_end;
            tcwm_pkg::S_UP_EV: o_cmd.visit_up = i_status.in_tol && !i_status.emit_wait;
            tcwm_pkg::S_FIN:   o_cmd.finish = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== hw/rtl/tcwm_dpath.sv =====
module tcwm_dpath #(
    parameter int TABLE_DEPTH = 4096,
    parameter int RESULT_CAP  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tcwm_pkg::t_in_item          i_in_item,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_index,
    input  logic [tcwm_pkg::ANGLE_W-1:0] i_cfg_data,
    input  logic                        i_out_stall,
    input  tcwm_pkg::t_cmd              i_cmd,
    output tcwm_pkg::t_status           o_status,
    output logic                        o_out_valid,
    output tcwm_pkg::t_out_item         o_out_item
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = AW + 1;
    localparam int EW = $clog2(RESULT_CAP + 1);

    tcwm_pkg::t_entry r_mem [TABLE_DEPTH];
    tcwm_pkg::t_entry r_rd;

    logic [tcwm_pkg::ANGLE_W-1:0] r_tol;
    logic [tcwm_pkg::COUNT_W-1:0] r_ecnt;
    logic [tcwm_pkg::ANGLE_W-1:0] r_s, r_m, r_l;
    logic [PW-1:0]                r_count, r_low, r_high, r_ptr;
    logic [AW-1:0]                r_mid, r_closest, r_rd_addr;
    logic                         r_first;
    logic [tcwm_pkg::ANGLE_W-1:0] r_best;
    logic [EW-1:0]                r_emit;
    logic                         r_pend_valid;
    tcwm_pkg::t_out_item          r_pend;
    logic                         r_out_valid;
    tcwm_pkg::t_out_item          r_out;

    logic [PW-1:0]                sat_count;
    logic [PW-1:0]                mid_full;
    logic [tcwm_pkg::ANGLE_W-1:0] d_small;
    logic                         better;
    logic                         exact;
    logic [PW-1:0]                n_low, n_high;
    logic [AW-1:0]                n_closest;
    logic                         cand, take, out_free, push;
    tcwm_pkg::t_out_item          push_item;
    tcwm_pkg::t_out_item          new_item;

    assign sat_count = (32'(r_ecnt) > TABLE_DEPTH) ? PW'(TABLE_DEPTH) : PW'(r_ecnt);
    assign mid_full  = r_low + ((r_high - PW'(1) - r_low) >> 1);

    assign d_small = tcwm_pkg::abs_diff(r_rd.small_a, r_s);
    assign better  = r_first || (d_small < r_best);
    assign exact   = (r_rd.small_a == r_s);

    always_comb begin
        n_low     = r_low;
        n_high    = r_high;
        n_closest = better ? r_mid : r_closest;
        if (r_rd.small_a < r_s) begin
            n_low = PW'(r_mid) + PW'(1);
        end else if (r_rd.small_a > r_s) begin
            n_high = PW'(r_mid);
        end else begin
            n_closest = r_mid;
        end
    end

    assign cand = (tcwm_pkg::abs_diff(r_rd.mid_a, r_m) <= r_tol)
               && (tcwm_pkg::abs_diff(r_rd.large_a, r_l) <= r_tol);
    assign take     = cand && (r_emit < EW'(RESULT_CAP));
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        new_item              = '0;
        new_item.found        = 1'b1;
        new_item.match_index  = tcwm_pkg::SLOT_W'(r_rd_addr);
        new_item.match_star_a = r_rd.id_a;
        new_item.match_star_b = r_rd.id_b;
        new_item.match_star_c = r_rd.id_c;
    end

    always_comb begin
        push      = 1'b0;
        push_item = r_pend;
        if (i_cmd.finish) begin
            push = 1'b1;
            if (r_pend_valid) begin
                push_item.last = 1'b1;
            end else begin
                push_item      = '0;
                push_item.last = 1'b1;
            end
        end else if ((i_cmd.visit_dn || i_cmd.visit_up) && take && r_pend_valid) begin
            push = 1'b1;
        end
    end

    always_comb begin
        o_status            = '0;
        o_status.in_query   = (i_in_item.mode == tcwm_pkg::MODE_QUERY);
        o_status.count_zero = (sat_count == '0);
        o_status.bs_done    = exact || !(n_low < n_high);
        o_status.ptr_zero   = (r_ptr == '0);
        o_status.ptr_end    = !(r_ptr < r_count);
        o_status.in_tol     = (d_small <= r_tol);
        o_status.emit_wait  = take && r_pend_valid && !out_free;
        o_status.out_free   = out_free;
    end

    // Catalog memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (32'(i_in_item.entry_index) < TABLE_DEPTH)) begin
            r_mem[AW'(i_in_item.entry_index)] <= '{
                small_a: i_in_item.angle_small,
                mid_a:   i_in_item.angle_mid,
                large_a: i_in_item.angle_large,
                id_a:    i_in_item.star_id_a,
                id_b:    i_in_item.star_id_b,
                id_c:    i_in_item.star_id_c
            };
        end
        if (i_cmd.bs_rd) begin
            r_rd      <= r_mem[AW'(mid_full)];
            r_rd_addr <= AW'(mid_full);
        end else if (i_cmd.rd_dn) begin
            r_rd      <= r_mem[AW'(r_ptr - PW'(1))];
            r_rd_addr <= AW'(r_ptr - PW'(1));
        end else if (i_cmd.rd_up) begin
            r_rd      <= r_mem[AW'(r_ptr)];
            r_rd_addr <= AW'(r_ptr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= tcwm_pkg::TOL_RESET;
            r_ecnt <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == tcwm_pkg::CFG_TOLERANCE) begin
                r_tol <= i_cfg_data;
            end else begin
                r_ecnt <= tcwm_pkg::COUNT_W'(i_cfg_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low        <= '0;
            r_high       <= '0;
            r_mid        <= '0;
            r_closest    <= '0;
            r_best       <= '1;
            r_first      <= 1'b0;
            r_ptr        <= '0;
            r_count      <= '0;
            r_emit       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_s          <= i_in_item.angle_small;
                r_m          <= i_in_item.angle_mid;
                r_l          <= i_in_item.angle_large;
                r_count      <= sat_count;
                r_low        <= '0;
                r_high       <= sat_count;
                r_closest    <= '0;
                r_best       <= '1;
                r_first      <= 1'b1;
                r_emit       <= '0;
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.bs_rd) begin
                r_mid <= AW'(mid_full);
            end
            if (i_cmd.bs_ev) begin
                if (better) begin
                    r_best <= d_small;
                end
                r_first   <= 1'b0;
                r_low     <= n_low;
                r_high    <= n_high;
                r_closest <= n_closest;
                r_ptr     <= PW'(n_closest) + PW'(1);
            end
            if (i_cmd.scan_init) begin
                r_ptr <= PW'(r_closest) + PW'(1);
            end
            if (i_cmd.visit_dn) begin
                r_ptr <= r_ptr - PW'(1);
            end
            if (i_cmd.visit_up) begin
                r_ptr <= r_ptr + PW'(1);
            end
            // Hold each candidate back one step so the final one can carry last
            if ((i_cmd.visit_dn || i_cmd.visit_up) && take) begin
                r_pend       <= new_item;
                r_pend_valid <= 1'b1;
                r_emit       <= r_emit + EW'(1);
            end
            if (i_cmd.finish) begin
                r_pend_valid <= 1'b0;
            end
            if (push) begin
                r_out_valid <= 1'b1;
                r_out       <= push_item;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== hw/rtl/triangle_catalog_window_match_core.sv =====
// Triangle catalog matcher.
// Input channel (i_in_valid / o_in_stall) carries one t_in_item per transaction.
// A load transaction (mode 0) writes one catalog slot and produces no result.
// A query transaction (mode 1) binary-searches the catalog on the smallest angle,
// then scans down and up from the closest entry while the smallest angle stays
// within tolerance, emitting matches (up to RESULT_CAP) on the output channel
// (o_out_valid / i_out_stall). The final result of a query has last set; a
// query without matches gives a single result with found clear.
// Configuration (i_cfg_valid / o_cfg_ready) writes the angle tolerance (index 0)
// or entry_count (index 1); o_cfg_ready is always high, write only when idle.
// Timing: loads may follow back to back. A query holds the input through the search
// steps (at most floor(log2(entry_count))+1 of them) and both scans; each search
// step and each entry read in the scans passes a read state and an evaluate state,
// set by the single registered read port of the catalog memory. The last result
// is written to the output register as the query leaves its finish state.
// A stalled output holds its transaction; the scan waits when a second match
// is ready and the output register is still full.
// Reset restores tolerance 26, entry_count 0 and an idle controller; the
// catalog contents are not cleared and must be loaded before use.
module triangle_catalog_window_match_core #(
    parameter int TABLE_DEPTH = 4096,
    parameter int RESULT_CAP  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  tcwm_pkg::t_in_item           i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output tcwm_pkg::t_out_item          o_out_item,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [tcwm_pkg::ANGLE_W-1:0] i_cfg_data
);

    tcwm_pkg::t_cmd    cmd;
    tcwm_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    tcwm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    tcwm_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .RESULT_CAP  (RESULT_CAP)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
